[design/lcf_pkg.sv]
// lcf_pkg: shared constants, types and helpers of the load-cell filter block
// no dependencies; used by every module in this folder by scoped names
`timescale 1ns / 1ps

package lcf_pkg;

    // channel count, a power of two; the channel index wraps around it
    localparam int CHANNELS = 4;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // converter bits actually used from the raw code field
    localparam int RAW_BITS = 24;
    localparam int RAW_W    = 24;

    localparam int DATA_W      = 32;
    localparam int FRAC_BITS   = 8;
    localparam int ALPHA_W     = 16;
    localparam int ALPHA_IDX_W = $clog2(ALPHA_W);
    localparam int DIFF_W      = DATA_W + 1;
    localparam int ALU_W       = DATA_W + ALPHA_W + 2;
    localparam int UNIT_SHIFT  = 24;
    localparam int QUO_W       = DATA_W + UNIT_SHIFT;
    localparam int CNT_W       = $clog2(QUO_W);

    localparam int NUM_SCALES  = 4;
    localparam int SCALE_IDX_W = 2;

    localparam int PADDR_W   = 5;
    localparam int REG_IDX_W = PADDR_W - 2;

    // register map, word index
    localparam logic [REG_IDX_W-1:0] REG_ALPHA  = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_SCALE0 = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_SCALE1 = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_SCALE2 = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_SCALE3 = REG_IDX_W'(4);

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(52429);
    localparam logic [DATA_W-1:0]  SCALE_RESET = DATA_W'(65536);

    // half lsb added before the q16 drop
    localparam logic [ALPHA_W-1:0] ROUND_HALF = ALPHA_W'(1) << (ALPHA_W - 1);

    // quotient magnitude limits for the saturating signed result
    localparam logic [QUO_W-1:0] QUO_NEG_LIM = QUO_W'(1) << (DATA_W - 1);
    localparam logic [QUO_W-1:0] QUO_POS_LIM = QUO_NEG_LIM - QUO_W'(1);

    // item kinds; the other codes behave as a plain sample
    localparam logic [1:0] KIND_TARE = 2'd1;
    localparam logic [1:0] KIND_LOAD = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_FILT,
        ST_TARE,
        ST_SETUP,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [ALPHA_W-1:0]                alpha;
        logic [NUM_SCALES-1:0][DATA_W-1:0] scale;
    } cfg_t;

    typedef struct packed {
        logic [DATA_W-1:0] filtered_raw;
        logic [DATA_W-1:0] tared_value;
        logic [DATA_W-1:0] units_value;
        logic              status;
    } res_t;

    // clamp a wide signed value into the 32-bit signed range
    function automatic logic [DATA_W-1:0] sat_data(input logic [ALU_W-1:0] x);
        logic [ALU_W-DATA_W:0] top_bits;
        top_bits = x[ALU_W-1:DATA_W-1];
        if (top_bits == '0 || top_bits == '1)
            return x[DATA_W-1:0];
        else if (x[ALU_W-1])
            return {1'b1, {(DATA_W-1){1'b0}}};
        else
            return {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

endpackage

[design/lcf_alu.sv]
// lcf_alu: shared add/subtract unit of the sequencer
// depends on lcf_pkg for the datapath width
`timescale 1ns / 1ps

module lcf_alu (
    input  logic [lcf_pkg::ALU_W-1:0] a,
    input  logic [lcf_pkg::ALU_W-1:0] b,
    input  logic                      sub,
    output logic [lcf_pkg::ALU_W-1:0] sum
);

    // two's complement add, or subtract through inverted b and carry in
    assign sum = a + (sub ? ~b : b) + lcf_pkg::ALU_W'(sub);

endmodule

[design/lcf_cfg.sv]
// lcf_cfg: apb register file, alpha and four channel scales
// depends on lcf_pkg for the register map and the cfg_t bundle
`timescale 1ns / 1ps

module lcf_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lcf_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output lcf_pkg::cfg_t               cfg
);

    logic [lcf_pkg::ALPHA_W-1:0] alpha_reg;
    logic [lcf_pkg::NUM_SCALES-1:0][lcf_pkg::DATA_W-1:0] scale_reg;
    logic [lcf_pkg::REG_IDX_W-1:0] reg_idx;
    logic wr_en;

    assign reg_idx = paddr[lcf_pkg::PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= lcf_pkg::ALPHA_RESET;
            for (int i = 0; i < lcf_pkg::NUM_SCALES; i++)
            begin
                scale_reg[i] <= lcf_pkg::SCALE_RESET;
            end
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                lcf_pkg::REG_ALPHA:  alpha_reg    <= pwdata[lcf_pkg::ALPHA_W-1:0];
                lcf_pkg::REG_SCALE0: scale_reg[0] <= pwdata;
                lcf_pkg::REG_SCALE1: scale_reg[1] <= pwdata;
                lcf_pkg::REG_SCALE2: scale_reg[2] <= pwdata;
                lcf_pkg::REG_SCALE3: scale_reg[3] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            lcf_pkg::REG_ALPHA:  prdata = 32'(alpha_reg);
            lcf_pkg::REG_SCALE0: prdata = scale_reg[0];
            lcf_pkg::REG_SCALE1: prdata = scale_reg[1];
            lcf_pkg::REG_SCALE2: prdata = scale_reg[2];
            lcf_pkg::REG_SCALE3: prdata = scale_reg[3];
            default:             prdata = '0;
        endcase
    end

    assign cfg.alpha = alpha_reg;
    assign cfg.scale = scale_reg;

endmodule

[design/lcf_seq.sv]
// lcf_seq: sequencer, channel state and operand registers around the shared alu
// depends on lcf_pkg and lcf_alu
`timescale 1ns / 1ps

module lcf_seq (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                kind,
    input  logic [1:0]                channel,
    input  logic [lcf_pkg::RAW_W-1:0] raw_code,
    input  logic [31:0]               offset_value,
    input  lcf_pkg::cfg_t             cfg,
    output logic                      res_valid,
    input  logic                      res_ready,
    output lcf_pkg::res_t             res
);

    localparam int DW = lcf_pkg::DATA_W;
    localparam int AW = lcf_pkg::ALU_W;
    localparam int QW = lcf_pkg::QUO_W;

    function automatic logic [AW-1:0] sx_data(input logic [DW-1:0] x);
        return {{(AW-DW){x[DW-1]}}, x};
    endfunction

    lcf_pkg::state_t state_reg, state_next;

    logic [1:0]                  kind_reg, kind_next;
    logic [lcf_pkg::CH_W-1:0]    ch_reg, ch_next;
    logic [DW-1:0]               raw_reg, raw_next;
    logic [AW-1:0]               acc_reg, acc_next;
    logic [lcf_pkg::DIFF_W-1:0]  diff_reg, diff_next;
    logic [DW-1:0]               filt_reg, filt_next;
    logic [DW-1:0]               tared_reg, tared_next;
    logic [DW-1:0]               rem_reg, rem_next;
    logic [DW-1:0]               div_reg, div_next;
    logic [QW-1:0]               quo_reg, quo_next;
    logic [lcf_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                        neg_reg, neg_next;
    logic                        zero_reg, zero_next;

    logic [DW-1:0] filter_state_reg [lcf_pkg::CHANNELS];
    logic [DW-1:0] channel_offset_reg [lcf_pkg::CHANNELS];

    logic          state_we, offset_we;
    logic [DW-1:0] wdata;

    logic [AW-1:0] alu_a, alu_b, alu_sum;
    logic          alu_sub;

    logic [DW-1:0] raw_ext, raw_fix, scale_cur, tmag, smag, units;
    logic [AW-1:0] filt_wide;
    logic [DW:0]   div_shift;
    logic          ch_scale_zero;

    lcf_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .sum (alu_sum)
    );

    // sign-extend the converter code and move it to q24.8
    assign raw_ext = {{(DW-lcf_pkg::RAW_BITS){raw_code[lcf_pkg::RAW_BITS-1]}},
                      raw_code[lcf_pkg::RAW_BITS-1:0]};
    assign raw_fix = {raw_ext[DW-lcf_pkg::FRAC_BITS-1:0], {lcf_pkg::FRAC_BITS{1'b0}}};

    assign scale_cur     = cfg.scale[lcf_pkg::SCALE_IDX_W'(ch_reg)];
    assign ch_scale_zero = (scale_cur == '0);
    assign filt_wide     = $signed(alu_sum) >>> lcf_pkg::ALPHA_W;
    assign div_shift     = {rem_reg, quo_reg[QW-1]};
    assign tmag          = tared_reg[DW-1] ? (~tared_reg + DW'(1)) : tared_reg;
    assign smag          = scale_cur[DW-1] ? (~scale_cur + DW'(1)) : scale_cur;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lcf_pkg::ST_IDLE:  if (in_valid) state_next = lcf_pkg::ST_LOAD;
            lcf_pkg::ST_LOAD:  state_next = (kind_reg == lcf_pkg::KIND_LOAD) ?
                                            lcf_pkg::ST_TARE : lcf_pkg::ST_MUL;
            lcf_pkg::ST_MUL:   if (cnt_reg == '0) state_next = lcf_pkg::ST_FILT;
            lcf_pkg::ST_FILT:  state_next = lcf_pkg::ST_TARE;
            lcf_pkg::ST_TARE:  state_next = lcf_pkg::ST_SETUP;
            lcf_pkg::ST_SETUP: state_next = ch_scale_zero ? lcf_pkg::ST_DONE : lcf_pkg::ST_DIV;
            lcf_pkg::ST_DIV:   if (cnt_reg == '0) state_next = lcf_pkg::ST_DONE;
            lcf_pkg::ST_DONE:  if (res_ready) state_next = lcf_pkg::ST_IDLE;
            default:           state_next = lcf_pkg::ST_IDLE;
        endcase
    end

    // control outputs and alu operand selection
    always_comb
    begin
        in_ready  = (state_reg == lcf_pkg::ST_IDLE);
        res_valid = (state_reg == lcf_pkg::ST_DONE);
        alu_a     = '0;
        alu_b     = '0;
        alu_sub   = 1'b0;
        unique case (state_reg)
            lcf_pkg::ST_LOAD:
            begin
                // old state minus new sample
                alu_a   = sx_data(filter_state_reg[ch_reg]);
                alu_b   = sx_data(raw_reg);
                alu_sub = 1'b1;
            end
            lcf_pkg::ST_MUL:
            begin
                // shift-add, alpha msb first
                alu_a = {acc_reg[AW-2:0], 1'b0};
                if (cfg.alpha[cnt_reg[lcf_pkg::ALPHA_IDX_W-1:0]])
                    alu_b = {{(AW-lcf_pkg::DIFF_W){diff_reg[lcf_pkg::DIFF_W-1]}}, diff_reg};
            end
            lcf_pkg::ST_FILT:
            begin
                // raw*65536 plus rounding half
                alu_a = acc_reg;
                alu_b = {{(AW-DW-lcf_pkg::ALPHA_W){raw_reg[DW-1]}}, raw_reg,
                         lcf_pkg::ROUND_HALF};
            end
            lcf_pkg::ST_TARE:
            begin
                alu_a   = sx_data(filt_reg);
                alu_b   = sx_data(channel_offset_reg[ch_reg]);
                alu_sub = 1'b1;
            end
            lcf_pkg::ST_DIV:
            begin
                // trial subtract of restoring division
                alu_a   = AW'(div_shift);
                alu_b   = AW'(div_reg);
                alu_sub = 1'b1;
            end
            default: ;
        endcase
    end

    // datapath next values
    always_comb
    begin
        kind_next  = kind_reg;
        ch_next    = ch_reg;
        raw_next   = raw_reg;
        acc_next   = acc_reg;
        diff_next  = diff_reg;
        filt_next  = filt_reg;
        tared_next = tared_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        zero_next  = zero_reg;
        state_we   = 1'b0;
        offset_we  = 1'b0;
        wdata      = raw_reg;
        case (state_reg)
            lcf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next = kind;
                    ch_next   = lcf_pkg::CH_W'(channel % lcf_pkg::CHANNELS);
                    raw_next  = (kind == lcf_pkg::KIND_LOAD) ? offset_value : raw_fix;
                    acc_next  = '0;
                    cnt_next  = lcf_pkg::CNT_W'(lcf_pkg::ALPHA_W - 1);
                end
            end
            lcf_pkg::ST_LOAD:
            begin
                if (kind_reg == lcf_pkg::KIND_LOAD)
                begin
                    state_we  = 1'b1;
                    offset_we = 1'b1;
                    wdata     = raw_reg;
                    filt_next = raw_reg;
                end
                else
                begin
                    diff_next = alu_sum[lcf_pkg::DIFF_W-1:0];
                end
            end
            lcf_pkg::ST_MUL:
            begin
                acc_next = alu_sum;
                cnt_next = cnt_reg - lcf_pkg::CNT_W'(1);
            end
            lcf_pkg::ST_FILT:
            begin
                wdata     = lcf_pkg::sat_data(filt_wide);
                filt_next = wdata;
                state_we  = 1'b1;
                offset_we = (kind_reg == lcf_pkg::KIND_TARE);
            end
            lcf_pkg::ST_TARE:
            begin
                tared_next = lcf_pkg::sat_data(alu_sum);
            end
            lcf_pkg::ST_SETUP:
            begin
                quo_next  = {tmag, {lcf_pkg::UNIT_SHIFT{1'b0}}};
                rem_next  = '0;
                div_next  = smag;
                neg_next  = tared_reg[DW-1] ^ scale_cur[DW-1];
                zero_next = ch_scale_zero;
                cnt_next  = lcf_pkg::CNT_W'(QW - 1);
            end
            lcf_pkg::ST_DIV:
            begin
                if (!alu_sum[AW-1])
                    rem_next = alu_sum[DW-1:0];
                else
                    rem_next = div_shift[DW-1:0];
                quo_next = {quo_reg[QW-2:0], ~alu_sum[AW-1]};
                cnt_next = cnt_reg - lcf_pkg::CNT_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lcf_pkg::ST_IDLE;
            for (int i = 0; i < lcf_pkg::CHANNELS; i++)
            begin
                filter_state_reg[i]   <= '0;
                channel_offset_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_we)
                filter_state_reg[ch_reg] <= wdata;
            if (offset_we)
                channel_offset_reg[ch_reg] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        ch_reg    <= ch_next;
        raw_reg   <= raw_next;
        acc_reg   <= acc_next;
        diff_reg  <= diff_next;
        filt_reg  <= filt_next;
        tared_reg <= tared_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
        quo_reg   <= quo_next;
        cnt_reg   <= cnt_next;
        neg_reg   <= neg_next;
        zero_reg  <= zero_next;
    end

    // sign and saturation of the quotient magnitude
    always_comb
    begin
        if (zero_reg)
            units = '0;
        else if (neg_reg)
            units = (quo_reg > lcf_pkg::QUO_NEG_LIM) ? {1'b1, {(DW-1){1'b0}}}
                                                     : (~quo_reg[DW-1:0] + DW'(1));
        else
            units = (quo_reg > lcf_pkg::QUO_POS_LIM) ? {1'b0, {(DW-1){1'b1}}}
                                                     : quo_reg[DW-1:0];
    end

    assign res.filtered_raw = filt_reg;
    assign res.tared_value  = tared_reg;
    assign res.units_value  = units;
    assign res.status       = zero_reg;

endmodule

[design/load_cell_filter_tare_scale_top.sv]
// load_cell_filter_tare_scale_top: four-channel load-cell filter, tare and scale; uses lcf_pkg
// a load-offset item skips the shift-add multiply and the filter step,
// and a zero scale skips the divide
// a 16-step shift-add multiply and a 56-step restoring divide share one add/subtract unit,
// and the block takes no input meanwhile
// a finished result sits in an output register, so the next input is taken while it waits
// reset (rst_n, async, low): filters and offsets zero, alpha 52429, scales 1.0 in q16.16
`timescale 1ns / 1ps

module load_cell_filter_tare_scale_top (
    input  logic                        clk,
    input  logic                        rst_n,
    // input channel
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  kind,
    input  logic [1:0]                  channel,
    input  logic [lcf_pkg::RAW_W-1:0]   raw_code,
    input  logic signed [31:0]          offset_value,
    // result channel
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [31:0]          filtered_raw,
    output logic signed [31:0]          tared_value,
    output logic signed [31:0]          units_value,
    output logic                        status,
    // apb register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lcf_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    lcf_pkg::cfg_t cfg;
    lcf_pkg::res_t res;
    lcf_pkg::res_t out_reg;
    logic          out_valid_reg;
    logic          res_valid, res_ready;

    // register file: alpha and the channel scales
    lcf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // filter, tare and divide sequencer
    lcf_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .channel      (channel),
        .raw_code     (raw_code),
        .offset_value (offset_value),
        .cfg          (cfg),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    // output register frees the sequencer once a result is parked here
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    // payload only moves when a new result is handed over
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
            out_reg <= res;
    end

    assign out_valid    = out_valid_reg;
    assign filtered_raw = out_reg.filtered_raw;
    assign tared_value  = out_reg.tared_value;
    assign units_value  = out_reg.units_value;
    assign status       = out_reg.status;

    // the sequencer is busy after taking a transaction, so in_ready falls
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again right after a transaction");

    // zero scale reports a zero units value
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> (units_value == 32'sd0))
    else $error("units value not cleared for zero scale");

    // a zero tared value divides to zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (tared_value == 32'sd0)) |-> (units_value == 32'sd0))
    else $error("nonzero units for zero tared value");

    // a result handed over while the output register is free or draining is presented as out_valid
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready) |=> out_valid)
    else $error("handed-over result not presented");

endmodule
